>>> rtl/core/fbad_pkg.sv
package fbad_pkg;

    localparam int RATIO_BITS     = 24;
    localparam int INV_BITS       = 24;
    localparam int FRAC_BITS      = 16;
    localparam int WHOLE_BITS     = 8;
    localparam int WEIGHT_BITS    = 17;
    localparam int SCALE_SHIFT    = 40;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE = 2'd1;

    localparam logic [RATIO_BITS-1:0]  RATIO_RESET   = 24'd361267;
    localparam logic [INV_BITS-1:0]    INVERSE_RESET = 24'd1521920;
    localparam logic [RATIO_BITS-1:0]  RATIO_MIN     = 24'd131072;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE    = 17'h10000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCUM,
        S_SCALE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic drain;
    } t_accum_ctrl;

    typedef struct packed {
        logic load;
        logic step;
    } t_scale_ctrl;

endpackage

>>> rtl/core/fbad_accum.sv
module fbad_accum #(
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_BITS    = 56
) (
    input  logic                                 i_clk,
    input  fbad_pkg::t_accum_ctrl                i_ctrl,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic [fbad_pkg::WEIGHT_BITS-1:0]     i_weight,
    output logic                                 o_sum_bit,
    output logic                                 o_sum_neg
);

    localparam int WB = fbad_pkg::WEIGHT_BITS;

    logic [SAMPLE_BITS-1:0] r_mcand;
    logic [SAMPLE_BITS-1:0] r_part;
    logic [WB-1:0]          r_weight;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_carry;

    logic [SAMPLE_BITS:0]   w_total;
    logic                   w_pbit;
    logic                   w_sbit;

    // The product leaves the multiplier one bit per cycle, LSB first, and is added
    // serially into the rotating window sum.
    always_comb begin
        w_total = {r_part[SAMPLE_BITS-1], r_part}
                + (r_weight[0] ? {r_mcand[SAMPLE_BITS-1], r_mcand} : '0);
        w_pbit  = w_total[0];
        w_sbit  = r_sum[0] ^ w_pbit ^ r_carry;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mcand  <= i_sample;
            r_weight <= i_weight;
            r_part   <= '0;
            r_carry  <= 1'b0;
            if (i_ctrl.clear) begin
                r_sum <= '0;
            end
        end else if (i_ctrl.step) begin
            r_part   <= w_total[SAMPLE_BITS:1];
            r_weight <= {1'b0, r_weight[WB-1:1]};
            r_carry  <= (r_sum[0] & w_pbit) | (r_sum[0] & r_carry) | (w_pbit & r_carry);
            r_sum    <= {w_sbit, r_sum[SUM_BITS-1:1]};
        end else if (i_ctrl.drain) begin
            r_sum <= {r_sum[SUM_BITS-1], r_sum[SUM_BITS-1:1]};
        end
    end

    assign o_sum_bit = r_sum[0];
    assign o_sum_neg = r_sum[SUM_BITS-1];

endmodule

>>> rtl/core/fbad_scale.sv
module fbad_scale #(
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_BITS    = 56
) (
    input  logic                              i_clk,
    input  fbad_pkg::t_scale_ctrl             i_ctrl,
    input  logic                              i_sum_bit,
    input  logic                              i_neg,
    input  logic [fbad_pkg::INV_BITS-1:0]     i_inverse,
    output logic [SAMPLE_BITS-1:0]            o_average
);

    localparam int IB        = fbad_pkg::INV_BITS;
    localparam int SHIFT     = fbad_pkg::SCALE_SHIFT;
    localparam int MUL_STEPS = (SUM_BITS > SHIFT) ? SUM_BITS : SHIFT;
    localparam int PROD_BITS = MUL_STEPS + IB;
    localparam int Q_BITS    = PROD_BITS - SHIFT;
    localparam logic [Q_BITS-1:0] LIMIT   = Q_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [Q_BITS-1:0] MAX_POS = LIMIT - Q_BITS'(1);

    logic [IB-1:0]          r_acc;
    logic [MUL_STEPS-1:0]   r_low;
    logic                   r_seen;

    logic                   w_mbit;
    logic [IB:0]            w_total;
    logic [PROD_BITS-1:0]   w_prod;
    logic [Q_BITS-1:0]      w_q;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS-1:0] w_out;

    // The sum arrives LSB first; a negative sum is negated on the fly by
    // inverting every bit after the first one.
    always_comb begin
        w_mbit  = i_neg ? (i_sum_bit ^ r_seen) : i_sum_bit;
        w_total = {1'b0, r_acc} + (w_mbit ? {1'b0, i_inverse} : '0);
        w_prod  = {r_acc, r_low};
        w_q     = w_prod[PROD_BITS-1:SHIFT];
        w_mag   = (w_q > LIMIT) ? LIMIT[SAMPLE_BITS-1:0] : w_q[SAMPLE_BITS-1:0];
        if (i_neg) begin
            w_out = '0 - w_mag;
        end else if (w_q > MAX_POS) begin
            w_out = MAX_POS[SAMPLE_BITS-1:0];
        end else begin
            w_out = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc  <= '0;
            r_seen <= 1'b0;
        end else if (i_ctrl.step) begin
            r_acc  <= w_total[IB:1];
            r_low  <= {w_total[0], r_low[MUL_STEPS-1:1]};
            r_seen <= r_seen | i_sum_bit;
        end
    end

    assign o_average = w_out;

endmodule

>>> rtl/core/fractional_box_average_decimator.sv
// Fractional-ratio boxcar decimator: one signed sample per input beat, one
// averaged sample per output beat each time a window closes. Window c starts at
// floor(c*ratio) and spans floor(ratio) samples; its first sample is weighted
// 1-f (or 1 when f is 0), its second 1+f, the rest 1, and samples between
// windows are dropped. The closing sum is scaled by inverse_ratio_q24 (register
// 1), truncated toward zero and saturated. ratio_q16 (register 0) below 2.0
// acts as 2.0. A beat with last_sample set is processed and then clears all
// window state. A dropped sample is handled in S_IDLE alone; a sample added to a
// window also passes through S_ACCUM (bit-serial multiply-accumulate into the
// window sum), and a sample that closes a window then passes through S_SCALE
// (bit-serial reciprocal multiply) and S_EMIT. No new sample is accepted until
// the block is back in S_IDLE. The result lands in an output register, and
// the block only waits when that register is still full at the end of the next
// closing sample.
module fractional_box_average_decimator #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fbad_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [fbad_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                 i_sample,
    input  logic                                   i_last_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [SAMPLE_BITS-1:0]                 o_average
);

    localparam int SUM_BITS  = SAMPLE_BITS + 24;
    localparam int MUL_STEPS = (SUM_BITS > fbad_pkg::SCALE_SHIFT) ? SUM_BITS
                                                                  : fbad_pkg::SCALE_SHIFT;
    localparam int CNT_BITS  = $clog2(MUL_STEPS);
    localparam int FB        = fbad_pkg::FRAC_BITS;
    localparam int HB        = fbad_pkg::WHOLE_BITS;

    fbad_pkg::t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [fbad_pkg::RATIO_BITS-1:0] r_ratio;
    logic [fbad_pkg::INV_BITS-1:0]   r_inverse;
    logic [FB-1:0] r_phase, n_phase;
    logic          r_skip, n_skip;
    logic [HB-1:0] r_pos, n_pos;
    logic          r_in_window, n_in_window;
    logic          r_close, n_close;
    logic          r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_average;

    logic [fbad_pkg::RATIO_BITS-1:0]  w_ratio;
    logic [HB-1:0]                    w_whole;
    logic [FB:0]                      w_next_phase;
    logic [HB-1:0]                    w_pos_eff;
    logic [fbad_pkg::WEIGHT_BITS-1:0] w_weight;
    logic                             w_closes;
    logic                             w_skip_item;
    logic                             w_load_out;
    logic                             w_sum_bit;
    logic                             w_sum_neg;
    logic [SAMPLE_BITS-1:0]           w_average;
    fbad_pkg::t_accum_ctrl            w_accum_ctrl;
    fbad_pkg::t_scale_ctrl            w_scale_ctrl;

    always_comb begin
        w_ratio      = (r_ratio < fbad_pkg::RATIO_MIN) ? fbad_pkg::RATIO_MIN : r_ratio;
        w_whole      = w_ratio[fbad_pkg::RATIO_BITS-1:FB];
        w_next_phase = {1'b0, r_phase} + {1'b0, w_ratio[FB-1:0]};
        w_pos_eff    = r_in_window ? r_pos : '0;
        w_skip_item  = !r_in_window && r_skip;
        w_closes     = ({1'b0, w_pos_eff} + (HB+1)'(1)) >= {1'b0, w_whole};
        if (w_pos_eff == HB'(0)) begin
            w_weight = (r_phase == '0) ? fbad_pkg::WEIGHT_ONE
                                       : fbad_pkg::WEIGHT_ONE - {1'b0, r_phase};
        end else if (w_pos_eff == HB'(1)) begin
            w_weight = fbad_pkg::WEIGHT_ONE + {1'b0, r_phase};
        end else begin
            w_weight = fbad_pkg::WEIGHT_ONE;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_pos        = r_pos;
        n_in_window  = r_in_window;
        n_close      = r_close;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_accum_ctrl = '0;
        w_scale_ctrl = '0;
        w_load_out   = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            fbad_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (w_skip_item) begin
                        n_skip = 1'b0;
                    end else begin
                        w_accum_ctrl.load  = 1'b1;
                        w_accum_ctrl.clear = !r_in_window;
                        n_close            = w_closes;
                        n_count            = '0;
                        n_state            = fbad_pkg::S_ACCUM;
                        if (w_closes) begin
                            n_skip      = w_next_phase[FB];
                            n_phase     = w_next_phase[FB-1:0];
                            n_in_window = 1'b0;
                            n_pos       = '0;
                        end else begin
                            n_in_window = 1'b1;
                            n_pos       = w_pos_eff + HB'(1);
                        end
                    end
                    if (i_last_sample) begin
                        n_phase     = '0;
                        n_skip      = 1'b0;
                        n_pos       = '0;
                        n_in_window = 1'b0;
                    end
                end
            end
            fbad_pkg::S_ACCUM: begin
                w_accum_ctrl.step = 1'b1;
                n_count           = r_count + CNT_BITS'(1);
                if (r_count == CNT_BITS'(SUM_BITS - 1)) begin
                    n_count = '0;
                    if (r_close) begin
                        w_scale_ctrl.load = 1'b1;
                        n_state           = fbad_pkg::S_SCALE;
                    end else begin
                        n_state = fbad_pkg::S_IDLE;
                    end
                end
            end
            fbad_pkg::S_SCALE: begin
                w_accum_ctrl.drain = 1'b1;
                w_scale_ctrl.step  = 1'b1;
                n_count            = r_count + CNT_BITS'(1);
                if (r_count == CNT_BITS'(MUL_STEPS - 1)) begin
                    n_count = '0;
                    n_state = fbad_pkg::S_EMIT;
                end
            end
            fbad_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = fbad_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbad_pkg::S_IDLE;
            r_count     <= '0;
            r_ratio     <= fbad_pkg::RATIO_RESET;
            r_inverse   <= fbad_pkg::INVERSE_RESET;
            r_phase     <= '0;
            r_skip      <= 1'b0;
            r_pos       <= '0;
            r_in_window <= 1'b0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_pos       <= n_pos;
            r_in_window <= n_in_window;
            r_close     <= n_close;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == fbad_pkg::REG_RATIO) begin
                r_ratio <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == fbad_pkg::REG_INVERSE) begin
                r_inverse <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_average <= w_average;
        end
    end

    fbad_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_ctrl    (w_accum_ctrl),
        .i_sample  (i_sample),
        .i_weight  (w_weight),
        .o_sum_bit (w_sum_bit),
        .o_sum_neg (w_sum_neg)
    );

    fbad_scale #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_ctrl    (w_scale_ctrl),
        .i_sum_bit (w_sum_bit),
        .i_neg     (w_sum_neg),
        .i_inverse (r_inverse),
        .o_average (w_average)
    );

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;

    a_scale_only_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbad_pkg::S_SCALE) |-> r_close)
        else $error("reciprocal multiply started for a beat that does not close a window");

    a_active_beat_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_skip_item) |=> (r_state == fbad_pkg::S_ACCUM))
        else $error("accepted window beat did not start accumulation");

    a_pos_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_window |-> (r_pos == '0))
        else $error("window position nonzero outside a window");

    a_emit_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbad_pkg::S_EMIT && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("closed window result not presented");

endmodule
